### hdl/blk2sp_pkg.sv
// Shared constants, tables and types for the BLAKE2sp hash engine.
// No dependencies; imported by every design module of the engine (not the checker).
`default_nettype none
package blk2sp_pkg;

    localparam int LEAF_COUNT = 8;

    localparam logic [31:0] LEAF_PARAM0 = 32'h0208_0020;
    localparam logic [31:0] LEAF_PARAM3 = 32'h2000_0000;
    localparam logic [31:0] ROOT_PARAM3 = 32'h2001_0000;
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

    localparam logic [31:0] IV [8] = '{
        32'h6A09_E667, 32'hBB67_AE85, 32'h3C6E_F372, 32'hA54F_F53A,
        32'h510E_527F, 32'h9B05_688C, 32'h1F83_D9AB, 32'h5BE0_CD19};

    localparam logic [3:0] SIGMA [10][16] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
        '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
          4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
          4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
        '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
          4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
        '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
          4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
        '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
          4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
          4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
          4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
        '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
          4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}};

    // load path into the compression unit
    typedef struct packed {
        logic        h_we;
        logic [2:0]  h_idx;
        logic        m_we;
        logic [3:0]  m_idx;
        logic [31:0] data;
    } t_cmp_load;

    // start request for one compression
    typedef struct packed {
        logic        start;
        logic [63:0] count;
        logic        last_blk;
        logic        last_node;
    } t_cmp_req;

    function automatic logic [3:0] sigma_at(logic [3:0] round, logic [3:0] j);
        logic [3:0] res;
        res = 4'd0;
        if (round < 4'd10) res = SIGMA[round][j];
        return res;
    endfunction

    // column then diagonal lanes: {a, b, c, d}
    function automatic logic [15:0] mix_lanes(logic [2:0] g);
        logic [15:0] res;
        case (g)
            3'd0:    res = {4'd0, 4'd4, 4'd8,  4'd12};
            3'd1:    res = {4'd1, 4'd5, 4'd9,  4'd13};
            3'd2:    res = {4'd2, 4'd6, 4'd10, 4'd14};
            3'd3:    res = {4'd3, 4'd7, 4'd11, 4'd15};
            3'd4:    res = {4'd0, 4'd5, 4'd10, 4'd15};
            3'd5:    res = {4'd1, 4'd6, 4'd11, 4'd12};
            3'd6:    res = {4'd2, 4'd7, 4'd8,  4'd13};
            default: res = {4'd3, 4'd4, 4'd9,  4'd14};
        endcase
        return res;
    endfunction

    function automatic logic [31:0] leaf_init(logic [2:0] leaf, logic [2:0] k);
        logic [31:0] res;
        res = IV[k];
        if (k == 3'd0) res = res ^ LEAF_PARAM0;
        if (k == 3'd2) res = res ^ {29'd0, leaf};
        if (k == 3'd3) res = res ^ LEAF_PARAM3;
        return res;
    endfunction

    function automatic logic [31:0] root_init(logic [2:0] k);
        logic [31:0] res;
        res = IV[k];
        if (k == 3'd0) res = res ^ LEAF_PARAM0;
        if (k == 3'd3) res = res ^ ROOT_PARAM3;
        return res;
    endfunction

endpackage
`default_nettype wire

### hdl/blk2sp_gmix.sv
// One half of the BLAKE2s G function on four state words.
// Depends on blk2sp_pkg.
`default_nettype none
module blk2sp_gmix import blk2sp_pkg::*; (
    input  logic        i_half,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    input  logic [31:0] i_d,
    input  logic [31:0] i_m,
    output logic [31:0] o_a,
    output logic [31:0] o_b,
    output logic [31:0] o_c,
    output logic [31:0] o_d
);
    logic [31:0] dx, bx;

    always_comb begin
        o_a = i_a + i_b + i_m;
        dx  = i_d ^ o_a;
        o_d = i_half ? {dx[7:0], dx[31:8]} : {dx[15:0], dx[31:16]};
        o_c = i_c + o_d;
        bx  = i_b ^ o_c;
        o_b = i_half ? {bx[6:0], bx[31:7]} : {bx[11:0], bx[31:12]};
    end
endmodule
`default_nettype wire

### hdl/blk2sp_compress.sv
// BLAKE2s compression unit: one half-G per cycle.
// Depends on blk2sp_pkg and blk2sp_gmix.
`default_nettype none
module blk2sp_compress import blk2sp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmp_load   i_load,
    input  t_cmp_req    i_req,
    input  logic [2:0]  i_h_idx,
    output logic [31:0] o_h_word,
    output logic        o_done
);
    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} t_state;

    t_state      r_state;
    logic [3:0]  r_round;
    logic [2:0]  r_g;
    logic        r_half;
    logic [31:0] r_v [16];
    logic [31:0] r_m [16];
    logic [31:0] r_h [8];

    logic [3:0]  ia, ib, ic, id, im;
    logic [31:0] ga, gb, gc, gd;

    always_comb begin
        {ia, ib, ic, id} = mix_lanes(r_g);
        im = sigma_at(r_round, {r_g, r_half});
    end

    blk2sp_gmix u_gmix (
        .i_half (r_half),
        .i_a    (r_v[ia]),
        .i_b    (r_v[ib]),
        .i_c    (r_v[ic]),
        .i_d    (r_v[id]),
        .i_m    (r_m[im]),
        .o_a    (ga),
        .o_b    (gb),
        .o_c    (gc),
        .o_d    (gd)
    );

    assign o_h_word = r_h[i_h_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_round <= 4'd0;
            r_g     <= 3'd0;
            r_half  <= 1'b0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_load.h_we) r_h[i_load.h_idx] <= i_load.data;
                    if (i_load.m_we) r_m[i_load.m_idx] <= i_load.data;
                    if (i_req.start) begin
                        for (int k = 0; k < 8; k++) begin
                            r_v[k] <= r_h[k];
                        end
                        for (int k = 0; k < 4; k++) begin
                            r_v[k+8] <= IV[k];
                        end
                        r_v[12] <= IV[4] ^ i_req.count[31:0];
                        r_v[13] <= IV[5] ^ i_req.count[63:32];
                        r_v[14] <= IV[6] ^ (i_req.last_blk  ? ALL_ONES : 32'd0);
                        r_v[15] <= IV[7] ^ (i_req.last_node ? ALL_ONES : 32'd0);
                        r_round <= 4'd0;
                        r_g     <= 3'd0;
                        r_half  <= 1'b0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_v[ia] <= ga;
                    r_v[ib] <= gb;
                    r_v[ic] <= gc;
                    r_v[id] <= gd;
                    r_half  <= ~r_half;
                    if (r_half) begin
                        r_g <= r_g + 3'd1;
                        if (r_g == 3'd7) begin
                            if (r_round == 4'd9) r_state <= S_FIN;
                            else r_round <= r_round + 4'd1;
                        end
                    end
                end
                S_FIN: begin
                    for (int k = 0; k < 8; k++) r_h[k] <= r_h[k] ^ r_v[k] ^ r_v[k+8];
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### hdl/blake2sp_hash_engine_core.sv
// BLAKE2sp-256 engine top level: byte dealer, leaf/root sequencer, memories.
// Depends on blk2sp_pkg and blk2sp_compress.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready): one beat carries a 32-bit word,
//    first byte in bits 7:0, a byte count 0..4 (5..7 act as 4) and a last flag.
//  - Output channel (o_out_valid / i_out_ready): after the last input beat
//    eight digest beats follow, word_index 0..7, last_word on the eighth.
//  - One input beat at a time: bytes are dealt one per cycle except while a
//    pending block is compressed. When a byte opens a leaf block while that
//    leaf still holds a full block, that block is compressed first: 8 chain
//    reads, 16 block reads, 160 half-G steps of the shared mix unit and 8
//    write-backs.
//  - Finalization: 8 leaf compressions then 4 root compressions come between
//    the last beat and the first digest beat.
//  - o_in_ready is high only while idle; the digest beats are held stable
//    while the receiver stalls, and no input is taken until all eight left.
//  - Reset (synchronous, active low) returns all hash state to its initial
//    values; after the eighth digest beat the engine resets itself the same
//    way and is ready for the next message. No memory clearing pass.
`default_nettype none
module blake2sp_hash_engine_core import blk2sp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    typedef enum logic [3:0] {
        S_IDLE, S_BYTE, S_LDH, S_LDM, S_RUN, S_WB, S_FIN, S_OUT
    } t_state;
    typedef enum logic [1:0] {M_ABS, M_FIN, M_ROOT} t_mode;

    t_state      r_state;
    t_mode       r_mode;
    logic [31:0] r_data;
    logic [2:0]  r_nb;
    logic        r_last;
    logic [2:0]  r_bidx;
    logic [9:0]  r_fill;       // bytes of current group, 0..512
    logic        r_pend;       // a full group was completed before
    logic        r_skip;       // block already flushed for this byte
    logic [2:0]  r_leaf;       // leaf in work, or root block number
    logic [4:0]  r_cnt;
    logic [3:0]  r_kd;         // r_cnt registered, aligned with read data
    logic [6:0]  r_len;
    logic [63:0] r_bcnt [8];
    logic [7:0]  r_cv;         // leaf chain written since reset or last digest
    logic [2:0]  r_out_idx;

    // block buffer: 128 words with byte lanes; chain memory: 64 words
    logic [3:0][7:0] r_buf [128];
    logic [31:0] r_buf_q;
    logic [31:0] r_chain [64];
    logic [31:0] r_chain_q;
    logic [5:0]  r_chain_ra;

    logic        buf_we;
    logic [6:0]  buf_waddr;
    logic [1:0]  buf_lane;
    logic [7:0]  buf_byte;
    logic [6:0]  buf_raddr;
    logic [5:0]  chain_raddr;
    logic        chain_we;
    logic [31:0] chain_word;
    logic [31:0] data_sh;

    logic        p_wrap;
    logic [9:0]  p;
    logic        pend_e;
    logic [10:0] lo, hi, fill_x;
    logic [6:0]  len;
    logic [31:0] fin_mask;

    t_cmp_load   cmp_load;
    t_cmp_req    cmp_req;
    logic [2:0]  h_idx;
    logic [31:0] h_word;
    logic        cmp_done;

    blk2sp_compress u_compress (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (cmp_load),
        .i_req    (cmp_req),
        .i_h_idx  (h_idx),
        .o_h_word (h_word),
        .o_done   (cmp_done)
    );

    // byte position after a possible group wrap
    always_comb begin
        p_wrap = (r_fill == 10'd512);
        p      = p_wrap ? 10'd0 : r_fill;
        pend_e = r_pend | p_wrap;
        data_sh = r_data >> {r_bidx[1:0], 3'b000};
    end

    // pending length of r_leaf at finalization
    always_comb begin
        lo     = {2'b00, r_leaf, 6'd0};
        hi     = lo + 11'd64;
        fill_x = {1'b0, r_fill};
        if (fill_x >= hi)     len = 7'd64;
        else if (fill_x > lo) len = 7'(fill_x - lo);
        else                  len = r_pend ? 7'd64 : 7'd0;
    end

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            fin_mask[8*b +: 8] = ({1'b0, r_kd, 2'(b)} < r_len) ? 8'hFF : 8'h00;
        end
    end

    always_comb begin
        buf_we    = (r_state == S_BYTE) && (r_bidx != r_nb) &&
                    !(!r_skip && pend_e && (p[5:0] == 6'd0));
        buf_waddr = p[8:2];
        buf_lane  = p[1:0];
        buf_byte  = data_sh[7:0];
        buf_raddr = {r_leaf, r_cnt[3:0]};
        if (r_mode == M_ROOT && r_state == S_LDM) chain_raddr = {r_leaf[1:0], r_cnt[3:0]};
        else chain_raddr = {r_leaf, r_cnt[2:0]};
        chain_we   = (r_state == S_WB);
        chain_word = r_cv[r_chain_ra[5:3]] ? r_chain_q
                                           : leaf_init(r_chain_ra[5:3], r_chain_ra[2:0]);
        h_idx      = (r_state == S_WB) ? r_cnt[2:0] : r_out_idx;
    end

    always_comb begin
        cmp_load = '0;
        if (r_state == S_LDH && r_cnt != 5'd0) begin
            cmp_load.h_we  = 1'b1;
            cmp_load.h_idx = r_kd[2:0];
            cmp_load.data  = (r_mode == M_ROOT) ? root_init(r_kd[2:0]) : chain_word;
        end else if (r_state == S_LDM && r_cnt != 5'd0) begin
            cmp_load.m_we  = 1'b1;
            cmp_load.m_idx = r_kd;
            unique case (r_mode)
                M_ABS:   cmp_load.data = r_buf_q;
                M_FIN:   cmp_load.data = r_buf_q & fin_mask;
                default: cmp_load.data = chain_word;
            endcase
        end
        cmp_req.start     = (r_state == S_LDM) && (r_cnt == 5'd16);
        cmp_req.count     = (r_mode == M_ROOT) ? {55'd0, 3'(r_leaf + 3'd1), 6'd0}
                                               : r_bcnt[r_leaf];
        cmp_req.last_blk  = (r_mode == M_FIN) || (r_mode == M_ROOT && r_leaf == 3'd3);
        cmp_req.last_node = (r_mode == M_FIN && r_leaf == 3'(LEAF_COUNT - 1)) ||
                            (r_mode == M_ROOT && r_leaf == 3'd3);
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (buf_we) r_buf[buf_waddr][buf_lane] <= buf_byte;
        r_buf_q <= r_buf[buf_raddr];
        if (chain_we) r_chain[{r_leaf, r_cnt[2:0]}] <= h_word;
        r_chain_q  <= r_chain[chain_raddr];
        r_chain_ra <= chain_raddr;
        r_kd       <= r_cnt[3:0];
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_digest_word = h_word;
    assign o_word_index  = r_out_idx;
    assign o_last_word   = (r_out_idx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= M_ABS;
            r_fill    <= 10'd0;
            r_pend    <= 1'b0;
            r_skip    <= 1'b0;
            r_cv      <= 8'd0;
            r_cnt     <= 5'd0;
            r_leaf    <= 3'd0;
            r_out_idx <= 3'd0;
            r_bidx    <= 3'd0;
            r_nb      <= 3'd0;
            r_last    <= 1'b0;
            for (int i = 0; i < 8; i++) r_bcnt[i] <= 64'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_data  <= i_data_word;
                        r_nb    <= (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;
                        r_last  <= i_last;
                        r_bidx  <= 3'd0;
                        r_skip  <= 1'b0;
                        r_state <= S_BYTE;
                    end
                end
                S_BYTE: begin
                    if (r_bidx == r_nb) begin
                        r_leaf  <= 3'd0;
                        r_state <= r_last ? S_FIN : S_IDLE;
                    end else if (!r_skip && pend_e && (p[5:0] == 6'd0)) begin
                        // leaf still holds a full block: compress it first
                        r_fill  <= p;
                        r_pend  <= pend_e;
                        r_skip  <= 1'b1;
                        r_leaf  <= p[8:6];
                        r_bcnt[p[8:6]] <= r_bcnt[p[8:6]] + 64'd64;
                        r_mode  <= M_ABS;
                        r_cnt   <= 5'd0;
                        r_state <= S_LDH;
                    end else begin
                        r_fill <= p + 10'd1;
                        r_pend <= pend_e;
                        r_skip <= 1'b0;
                        r_bidx <= r_bidx + 3'd1;
                    end
                end
                S_FIN: begin
                    r_len   <= len;
                    r_bcnt[r_leaf] <= r_bcnt[r_leaf] + 64'(len);
                    r_mode  <= M_FIN;
                    r_cnt   <= 5'd0;
                    r_state <= S_LDH;
                end
                S_LDH: begin
                    if (r_cnt == 5'd8) begin
                        r_cnt   <= 5'd0;
                        r_state <= S_LDM;
                    end else r_cnt <= r_cnt + 5'd1;
                end
                S_LDM: begin
                    if (r_cnt == 5'd16) begin
                        r_cnt   <= 5'd0;
                        r_state <= S_RUN;
                    end else r_cnt <= r_cnt + 5'd1;
                end
                S_RUN: begin
                    if (cmp_done) begin
                        if (r_mode != M_ROOT) r_state <= S_WB;
                        else if (r_leaf == 3'd3) begin
                            r_out_idx <= 3'd0;
                            r_state   <= S_OUT;
                        end else begin
                            r_leaf  <= r_leaf + 3'd1;
                            r_state <= S_LDM;    // root chain stays in the unit
                        end
                    end
                end
                S_WB: begin
                    if (r_cnt[2:0] == 3'd7) begin
                        r_cv[r_leaf] <= 1'b1;
                        r_cnt <= 5'd0;
                        if (r_mode == M_ABS) r_state <= S_BYTE;
                        else if (r_leaf == 3'(LEAF_COUNT - 1)) begin
                            r_leaf  <= 3'd0;
                            r_mode  <= M_ROOT;
                            r_state <= S_LDH;
                        end else begin
                            r_leaf  <= r_leaf + 3'd1;
                            r_state <= S_FIN;
                        end
                    end else r_cnt <= r_cnt + 5'd1;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        if (r_out_idx == 3'd7) begin
                            r_cv   <= 8'd0;
                            r_fill <= 10'd0;
                            r_pend <= 1'b0;
                            for (int i = 0; i < 8; i++) r_bcnt[i] <= 64'd0;
                            r_state <= S_IDLE;
                        end
                        r_out_idx <= r_out_idx + 3'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### hdl/blk2sp_checker.sv
// Port-level checks for the BLAKE2sp engine, bound to the top level.
// Depends on blake2sp_hash_engine_core port names.
`default_nettype none
module blk2sp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic [31:0] i_data_word,
    input wire logic [2:0]  i_byte_count,
    input wire logic        i_last,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] o_digest_word,
    input wire logic [2:0]  o_word_index,
    input wire logic        o_last_word
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_digest_word) && $stable(o_word_index))
        else $error("digest beat changed while stalled");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while digest pending");

    a_end_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_last_word |=> !o_out_valid)
        else $error("beat after last digest word");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_word |=>
            o_out_valid && (o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest words not in order");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_word == (o_word_index == 3'd7)))
        else $error("last_word flag mismatch");
endmodule

bind blake2sp_hash_engine_core blk2sp_checker u_blk2sp_checker (.*);
`default_nettype wire
